FILE: design/rpc_pkg.sv
// Shared types, constants and colormap tables of the raster pixel colorizer.
package rpc_pkg;

    localparam int BAND_W     = 32;
    localparam int NUM_W      = 33;
    localparam int DIFF_W     = 34;
    localparam int PT_W       = 17;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 5;
    localparam int CMAP_N_PTS = 44;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic signed [BAND_W-1:0] band_first;
        logic signed [BAND_W-1:0] band_second;
        logic signed [BAND_W-1:0] band_third;
    } sample_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    typedef enum logic [1:0] {
        MODE_GRAY   = 2'd0,
        MODE_PSEUDO = 2'd1,
        MODE_RGB    = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        REG_MIN_VALUE   = 2'd0,
        REG_MAX_VALUE   = 2'd1,
        REG_RENDER_MODE = 2'd2,
        REG_COLOR_MAP   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] min_value;
        logic signed [31:0] max_value;
        logic [1:0]         render_mode;
        logic [2:0]         color_map;
    } cfg_t;

    typedef struct packed {
        logic [PT_W-1:0] r;
        logic [PT_W-1:0] g;
        logic [PT_W-1:0] b;
    } cmap_pt_t;

    // Control points of all maps, Q1.16, maps stored back to back.
    localparam cmap_pt_t CMAP_PTS [CMAP_N_PTS] = '{
        '{0,0,0}, '{65536,65536,65536},
        '{17498,328,21561}, '{18481,13828,34210}, '{18285,22741,39715},
        '{14352,30409,36438}, '{8454,36831,28770}, '{10027,45679,24576},
        '{27525,53215,15860}, '{59179,62325,22872}, '{65339,59048,44892},
        '{61669,48038,62390}, '{63504,28312,57803}, '{60424,24969,6947},
        '{0,0,33751}, '{0,0,65536}, '{0,32768,65536}, '{0,65536,65536},
        '{32768,65536,32768}, '{65536,65536,0}, '{65536,32768,0}, '{65536,0,0},
        '{32768,0,0},
        '{12452,3277,15139}, '{20578,2687,30540}, '{25428,16777,30474},
        '{28049,30540,24510}, '{26477,44564,4391}, '{0,51184,13631},
        '{0,55575,33096}, '{0,57475,48890}, '{0,51380,61276},
        '{16253,42533,63504}, '{30867,28574,4391}, '{43647,53740,46662},
        '{59376,51118,12321}, '{65339,47710,5112}, '{64750,41681,5636},
        '{52232,19399,6947}, '{50790,6291,3736}, '{63504,18022,2818},
        '{63635,36766,10813}, '{65405,49807,16253}, '{64815,58655,19661}
    };

    function automatic cmap_pt_t cmap_point(input logic [IDX_W-1:0] idx);
        cmap_pt_t pt;
        pt = '0;
        if (idx < IDX_W'(CMAP_N_PTS))
        begin
            pt = CMAP_PTS[idx];
        end
        return pt;
    endfunction

    // Index of the first control point of a map; unknown maps fall back to gray.
    function automatic logic [IDX_W-1:0] cmap_first(input logic [2:0] sel);
        logic [IDX_W-1:0] f;
        case (sel)
            3'd1:    f = IDX_W'(2);
            3'd2:    f = IDX_W'(14);
            3'd3:    f = IDX_W'(23);
            default: f = IDX_W'(0);
        endcase
        return f;
    endfunction

    // Number of segments of a map (control points minus one).
    function automatic logic [CNT_W-1:0] cmap_segs(input logic [2:0] sel);
        logic [CNT_W-1:0] n;
        case (sel)
            3'd1:    n = CNT_W'(11);
            3'd2:    n = CNT_W'(8);
            3'd3:    n = CNT_W'(20);
            default: n = CNT_W'(1);
        endcase
        return n;
    endfunction

endpackage

FILE: design/rpc_regs.sv
// Configuration register file with its bus port.
module rpc_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rpc_pkg::ADDR_W-1:0]   paddr,
    input  logic [rpc_pkg::DATA_W-1:0]   pwdata,
    output logic [rpc_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output rpc_pkg::cfg_t                cfg
);
    import rpc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            case (paddr[ADDR_W-1:2])
                REG_MIN_VALUE:   cfg_next.min_value   = pwdata;
                REG_MAX_VALUE:   cfg_next.max_value   = pwdata;
                REG_RENDER_MODE: cfg_next.render_mode = pwdata[1:0];
                REG_COLOR_MAP:   cfg_next.color_map   = pwdata[2:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_value   <= 32'sd0;
            cfg_reg.max_value   <= 32'sd255;
            cfg_reg.render_mode <= MODE_GRAY;
            cfg_reg.color_map   <= 3'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (paddr[ADDR_W-1:2])
            REG_MIN_VALUE:   prdata = cfg_reg.min_value;
            REG_MAX_VALUE:   prdata = cfg_reg.max_value;
            REG_RENDER_MODE: prdata = {30'd0, cfg_reg.render_mode};
            REG_COLOR_MAP:   prdata = {29'd0, cfg_reg.color_map};
            default:         prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

endmodule

FILE: design/rpc_divider.sv
// Pipelined restoring divider lane, one quotient bit per stage.
module rpc_divider #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                        clk,
    input  logic                        adv,
    input  logic [rpc_pkg::NUM_W-1:0]   num,
    input  logic [rpc_pkg::NUM_W-1:0]   den,
    input  logic                        full,
    output logic [FRACTION_BITS:0]      quot,
    output logic                        quot_full
);
    import rpc_pkg::*;

    localparam int NSTG = FRACTION_BITS + 1;

    logic [NUM_W-1:0]         rem_reg  [NSTG];
    logic [FRACTION_BITS:0]   q_reg    [NSTG];
    logic                     full_reg [NSTG];
    logic [NUM_W-1:0]         rem_next [NSTG];
    logic [FRACTION_BITS:0]   q_next   [NSTG];
    logic                     full_next[NSTG];

    genvar i;
    generate
        for (i = 0; i < NSTG; i++)
        begin : g_stage
            logic [NUM_W-1:0]       rem_in;
            logic [FRACTION_BITS:0] q_in;
            logic                   full_in;
            logic [NUM_W:0]         shifted;
            logic                   ge;

            if (i == 0)
            begin : g_first
                assign rem_in  = num;
                assign q_in    = '0;
                assign full_in = full;
            end
            else
            begin : g_rest
                assign rem_in  = rem_reg[i-1];
                assign q_in    = q_reg[i-1];
                assign full_in = full_reg[i-1];
            end

            // The remainder stays below the divisor, so one compare and subtract per bit.
            assign shifted = {rem_in, 1'b0};
            assign ge      = (shifted >= {1'b0, den});

            always_comb
            begin
                if (ge)
                begin
                    rem_next[i] = NUM_W'(shifted - {1'b0, den});
                end
                else
                begin
                    rem_next[i] = shifted[NUM_W-1:0];
                end
                q_next[i]    = {q_in[FRACTION_BITS-1:0], ge};
                full_next[i] = full_in;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[i]  <= rem_next[i];
                    q_reg[i]    <= q_next[i];
                    full_reg[i] <= full_next[i];
                end
            end
        end
    endgenerate

    assign quot      = q_reg[NSTG-1];
    assign quot_full = full_reg[NSTG-1];

endmodule

FILE: design/rpc_shade.sv
// Rounding, byte conversion and colormap interpolation stages after the divider.
module rpc_shade #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                          clk,
    input  logic                          adv,
    input  logic [2:0][FRACTION_BITS:0]   quot,
    input  logic [2:0]                    quot_full,
    input  rpc_pkg::cfg_t                 cfg,
    output rpc_pkg::pixel_t               pixel
);
    import rpc_pkg::*;

    localparam int F  = FRACTION_BITS;
    localparam int TW = F + 1;
    localparam int GW = F + 9;
    localparam int PW = F + 1 + CNT_W;
    localparam int MW = PT_W + TW;
    localparam int CW = MW + 1;
    localparam int YW = CW + 8;
    localparam logic [TW-1:0] ONE  = {1'b1, {F{1'b0}}};
    localparam logic [GW-1:0] HALF = GW'(1) << (F - 1);
    localparam logic [YW-1:0] RND  = YW'(1) << (15 + F);

    // Stage T: rounded fraction.
    logic [2:0][TW-1:0] t_reg, t_next;
    // Stage P: direct bytes and colormap position.
    logic [2:0][7:0]    gb_p_reg, gb_p_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [TW-1:0]      u_reg, u_next;
    // Stage L: control points and weights.
    logic [2:0][7:0]    gb_l_reg;
    logic [2:0][PT_W-1:0] a_reg, a_next, b_reg, b_next;
    logic [TW-1:0]      w0_reg, w0_next, w1_reg;
    // Stage M: weighted products.
    logic [2:0][7:0]    gb_m_reg;
    logic [2:0][MW-1:0] pa_reg, pa_next, pb_reg, pb_next;
    // Stage O: output pixel.
    pixel_t             pixel_reg, pixel_next;

    cmap_pt_t           pt_a, pt_b;
    logic [TW:0]        t_sum [3];
    logic [GW-1:0]      g_scaled [3];
    logic [PW-1:0]      pos;
    logic [IDX_W-1:0]   seg;
    logic [CNT_W-1:0]   nsegs;
    logic [CW-1:0]      c_sum [3];
    logic [YW-1:0]      c_scaled [3];
    logic [2:0][7:0]    cm_byte;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            t_sum[k] = {1'b0, quot[k]} + (TW+1)'(1);
            t_next[k] = quot_full[k] ? ONE : t_sum[k][TW:1];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            g_scaled[k] = {t_reg[k], 8'd0} - GW'(t_reg[k]) + HALF;
            gb_p_next[k] = g_scaled[k][F+7:F];
        end
        nsegs = cmap_segs(cfg.color_map);
        pos   = PW'(t_reg[0]) * PW'(nsegs);
        seg   = pos[PW-1:F];
        u_next = {1'b0, pos[F-1:0]};
        // At full intensity the last segment is used with full weight on its end point.
        if (seg >= IDX_W'(nsegs))
        begin
            seg    = IDX_W'(nsegs) - IDX_W'(1);
            u_next = ONE;
        end
        idx_next = cmap_first(cfg.color_map) + seg;
    end

    always_comb
    begin
        pt_a = cmap_point(idx_reg);
        pt_b = cmap_point(idx_reg + IDX_W'(1));
        a_next[0] = pt_a.r;
        a_next[1] = pt_a.g;
        a_next[2] = pt_a.b;
        b_next[0] = pt_b.r;
        b_next[1] = pt_b.g;
        b_next[2] = pt_b.b;
        w0_next   = ONE - u_reg;
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pa_next[k] = MW'(a_reg[k]) * MW'(w0_reg);
            pb_next[k] = MW'(b_reg[k]) * MW'(w1_reg);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            c_sum[k]    = CW'(pa_reg[k]) + CW'(pb_reg[k]);
            c_scaled[k] = {c_sum[k], 8'd0} - YW'(c_sum[k]) + RND;
            cm_byte[k]  = c_scaled[k][F+23:F+16];
        end
        pixel_next.alpha = ALPHA_OPAQUE;
        case (cfg.render_mode)
            MODE_GRAY:
            begin
                pixel_next.red   = gb_m_reg[0];
                pixel_next.green = gb_m_reg[0];
                pixel_next.blue  = gb_m_reg[0];
            end
            MODE_PSEUDO:
            begin
                pixel_next.red   = cm_byte[0];
                pixel_next.green = cm_byte[1];
                pixel_next.blue  = cm_byte[2];
            end
            default:
            begin
                pixel_next.red   = gb_m_reg[0];
                pixel_next.green = gb_m_reg[1];
                pixel_next.blue  = gb_m_reg[2];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg     <= t_next;
            gb_p_reg  <= gb_p_next;
            idx_reg   <= idx_next;
            u_reg     <= u_next;
            gb_l_reg  <= gb_p_reg;
            a_reg     <= a_next;
            b_reg     <= b_next;
            w0_reg    <= w0_next;
            w1_reg    <= u_reg;
            gb_m_reg  <= gb_l_reg;
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
            pixel_reg <= pixel_next;
        end
    end

    assign pixel = pixel_reg;

endmodule

FILE: design/raster_pixel_colorizer.sv
// Top level of the raster pixel colorizer.
// Each sample item carries three band values; each pixel item carries one RGBA pixel.
// Both channels use valid and stall: an item moves at a clock edge where valid is
// high and stall is low. Configuration registers are written over the bus port
// at byte addresses 0, 4, 8 and 12; the user must write them only while no item is
// in flight, which the block itself does not enforce. The block is a pipeline of
// FRACTION_BITS + 8 stages (24 at the default): an input register, a normalization
// stage, one divider stage per quotient bit, then rounding, byte conversion,
// colormap lookup, multiply and output stages. A new sample is accepted every
// cycle while the pipeline is not held; the divider lanes set the depth.
// When the receiver stalls a valid pixel, the whole pipeline holds and
// sample_stall rises in the same cycle, so nothing is lost or repeated.
// Reset empties the pipeline and loads min 0, max 255, gray mode and gray map.
module raster_pixel_colorizer #(
    parameter int SAMPLE_WIDTH  = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sample_valid,
    output logic                        sample_stall,
    input  rpc_pkg::sample_t            sample,
    output logic                        pixel_valid,
    input  logic                        pixel_stall,
    output rpc_pkg::pixel_t             pixel,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rpc_pkg::ADDR_W-1:0]  paddr,
    input  logic [rpc_pkg::DATA_W-1:0]  pwdata,
    output logic [rpc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import rpc_pkg::*;

    localparam int LAT = FRACTION_BITS + 8;

    cfg_t                        cfg;
    logic                        adv;
    logic [LAT-1:0]              valid_reg, valid_next;
    sample_t                     in_reg;
    logic signed [DIFF_W-1:0]    den_reg;
    logic [NUM_W-1:0]            divisor_reg;
    logic [2:0][NUM_W-1:0]       num_reg, num_next;
    logic [2:0]                  full_reg, full_next;
    logic [2:0][BAND_W-1:0]      band;
    logic signed [DIFF_W-1:0]    v_ext [3];
    logic signed [DIFF_W-1:0]    diff [3];
    logic signed [DIFF_W-1:0]    min_ext;
    logic [2:0][FRACTION_BITS:0] quot;
    logic [2:0]                  quot_full;

    rpc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The whole pipeline moves unless a finished pixel is held by the receiver.
    assign adv          = !(valid_reg[LAT-1] && pixel_stall);
    assign sample_stall = !adv;
    assign pixel_valid  = valid_reg[LAT-1];
    assign valid_next   = {valid_reg[LAT-2:0], sample_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    // Range and divisor follow the registers; they are settled before any item needs them.
    always_ff @(posedge clk)
    begin
        den_reg     <= DIFF_W'(cfg.max_value) - DIFF_W'(cfg.min_value);
        divisor_reg <= (cfg.max_value > cfg.min_value)
                     ? NUM_W'(DIFF_W'(cfg.max_value) - DIFF_W'(cfg.min_value))
                     : NUM_W'(1);
    end

    assign band[0] = in_reg.band_first;
    assign band[1] = in_reg.band_second;
    assign band[2] = in_reg.band_third;
    assign min_ext = DIFF_W'(cfg.min_value);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            v_ext[k] = {{(DIFF_W-SAMPLE_WIDTH){band[k][SAMPLE_WIDTH-1]}},
                        band[k][SAMPLE_WIDTH-1:0]};
            diff[k]  = v_ext[k] - min_ext;
            num_next[k]  = '0;
            full_next[k] = 1'b0;
            if ((den_reg > 0) && (diff[k] > 0))
            begin
                if (diff[k] >= den_reg)
                begin
                    full_next[k] = 1'b1;
                end
                else
                begin
                    num_next[k] = diff[k][NUM_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_reg   <= sample;
            num_reg  <= num_next;
            full_reg <= full_next;
        end
    end

    genvar k;
    generate
        for (k = 0; k < 3; k++)
        begin : g_lane
            rpc_divider #(
                .FRACTION_BITS (FRACTION_BITS)
            ) u_div (
                .clk       (clk),
                .adv       (adv),
                .num       (num_reg[k]),
                .den       (divisor_reg),
                .full      (full_reg[k]),
                .quot      (quot[k]),
                .quot_full (quot_full[k])
            );
        end
    endgenerate

    rpc_shade #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_shade (
        .clk       (clk),
        .adv       (adv),
        .quot      (quot),
        .quot_full (quot_full),
        .cfg       (cfg),
        .pixel     (pixel)
    );

endmodule

FILE: design/rpc_checker.sv
// Port-level checks of the raster pixel colorizer and their binding.
module rpc_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            sample_stall,
    input logic            pixel_valid,
    input logic            pixel_stall,
    input rpc_pkg::pixel_t pixel
);
    import rpc_pkg::*;

    // The input side waits exactly when a finished pixel is held back.
    a_stall_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall == (pixel_valid && pixel_stall))
        else $error("sample_stall does not match the held output");

    a_alpha_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid |-> (pixel.alpha == ALPHA_OPAQUE))
        else $error("pixel alpha is not opaque");

    a_held_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && pixel_stall) |=> pixel_valid)
        else $error("stalled pixel dropped");

    a_held_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && pixel_stall) |=> $stable(pixel))
        else $error("stalled pixel changed");

endmodule

bind raster_pixel_colorizer rpc_checker u_rpc_checker (.*);

FILE: tb/sv/tb_raster_pixel_colorizer.sv
// Self-checking testbench of the raster pixel colorizer with a local pixel predictor.
`timescale 1ns / 100ps

module tb_raster_pixel_colorizer;
    import rpc_pkg::*;

    localparam int FRAC       = 16;
    localparam int LATENCY    = FRAC + 8;
    localparam int CYCLE_CAP  = 400000;
    localparam int RANDOM_N   = 550;

    logic            clk;
    logic            rst_n;
    logic            sample_valid;
    logic            sample_stall;
    sample_t         sample;
    logic            pixel_valid;
    logic            pixel_stall;
    pixel_t          pixel;
    logic            psel;
    logic            penable;
    logic            pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic            pready;

    // Local copy of the configuration registers.
    logic signed [31:0] lo_bound;
    logic signed [31:0] hi_bound;
    logic [1:0]         mode_reg;
    logic [2:0]         map_reg;

    sample_t pending_samples[$];
    pixel_t  expected_pixels[$];
    int      error_count;
    int      cycle_count;
    bit      quiet_stretch;

    raster_pixel_colorizer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Normalized fraction of a sample, 0 .. 2^FRAC, rounded half up.
    function automatic longint unsigned norm_fraction(input logic signed [31:0] v);
        longint num;
        longint den;
        num = longint'(v) - longint'(lo_bound);
        den = longint'(hi_bound) - longint'(lo_bound);
        if (den <= 0 || num <= 0)
            return 0;
        if (num >= den)
            return 64'd1 << FRAC;
        return ((unsigned'(num) << (FRAC + 1)) + unsigned'(den))
               / (2 * unsigned'(den));
    endfunction

    function automatic logic [7:0] intensity_byte(input logic signed [31:0] v);
        if (hi_bound <= lo_bound)
            return 8'd0;
        return 8'((norm_fraction(v) * 255 + (64'd1 << (FRAC - 1))) >> FRAC);
    endfunction

    function automatic pixel_t colorize(input sample_t s);
        pixel_t px;
        int first_pt;
        int n_pts;
        longint unsigned one;
        longint unsigned t;
        longint unsigned pos;
        longint unsigned seg;
        longint unsigned wgt;
        longint unsigned a [3];
        longint unsigned b [3];
        longint unsigned mix;
        cmap_pt_t pa;
        cmap_pt_t pb;
        px.alpha = 8'hFF;
        case (mode_reg)
            MODE_GRAY:
            begin
                px.red   = intensity_byte(s.band_first);
                px.green = px.red;
                px.blue  = px.red;
            end
            MODE_PSEUDO:
            begin
                case (map_reg)
                    3'd1:    begin first_pt = 2;  n_pts = 12; end
                    3'd2:    begin first_pt = 14; n_pts = 9;  end
                    3'd3:    begin first_pt = 23; n_pts = 21; end
                    default: begin first_pt = 0;  n_pts = 2;  end
                endcase
                one = 64'd1 << FRAC;
                t   = norm_fraction(s.band_first);
                pos = t * (n_pts - 1);
                seg = pos >> FRAC;
                wgt = pos & (one - 1);
                if (seg >= n_pts - 1)
                begin
                    seg = n_pts - 2;
                    wgt = one;
                end
                pa = CMAP_PTS[first_pt + seg];
                pb = CMAP_PTS[first_pt + seg + 1];
                a[0] = pa.r; a[1] = pa.g; a[2] = pa.b;
                b[0] = pb.r; b[1] = pb.g; b[2] = pb.b;
                for (int ch = 0; ch < 3; ch++)
                begin
                    mix = a[ch] * (one - wgt) + b[ch] * wgt;
                    mix = (mix * 255 + (64'd1 << (15 + FRAC))) >> (16 + FRAC);
                    if (ch == 0) px.red = 8'(mix);
                    else if (ch == 1) px.green = 8'(mix);
                    else px.blue = 8'(mix);
                end
            end
            default:
            begin
                px.red   = intensity_byte(s.band_first);
                px.green = intensity_byte(s.band_second);
                px.blue  = intensity_byte(s.band_third);
            end
        endcase
        return px;
    endfunction

    function automatic logic [31:0] rand_band();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'(lo_bound) + $urandom_range(0, 40) - 20;
            3:       return 32'(hi_bound) + $urandom_range(0, 40) - 20;
            4:       return $urandom;
            default: return 32'(lo_bound) + ((32'(hi_bound) - 32'(lo_bound)) / 1000)
                            * $urandom_range(0, 1000) + $urandom_range(0, 3);
        endcase
    endfunction

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIN_VALUE:   lo_bound = value;
            REG_MAX_VALUE:   hi_bound = value;
            REG_RENDER_MODE: mode_reg = value[1:0];
            default:         map_reg  = value[2:0];
        endcase
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || expected_pixels.size() != 0 || sample_valid)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic push_sample(input logic [31:0] b0, input logic [31:0] b1,
                               input logic [31:0] b2);
        sample_t s;
        s.band_first  = b0;
        s.band_second = b1;
        s.band_third  = b2;
        pending_samples = {pending_samples, s};
    endtask

    task automatic set_config(input logic [31:0] lo, input logic [31:0] hi,
                              input logic [1:0] md, input logic [2:0] cm);
        wait_drained();
        write_reg(REG_MIN_VALUE, lo);
        write_reg(REG_MAX_VALUE, hi);
        write_reg(REG_RENDER_MODE, 32'(md));
        write_reg(REG_COLOR_MAP, 32'(cm));
    endtask

    // Driver: one item offered at a time, held while stalled.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
                void'(pending_samples.pop_front());
            if (pending_samples.size() != 0
                && (quiet_stretch || $urandom_range(0, 99) >= 38))
            begin
                sample_valid <= 1'b1;
                sample <= pending_samples[0];
            end
            else if (!(sample_valid && sample_stall))
                sample_valid <= 1'b0;
            pixel_stall <= !quiet_stretch && ($urandom_range(0, 99) < 38);
        end
    end

    // Predict at acceptance; configuration only changes while idle.
    always @(posedge clk)
    begin
        if (rst_n && sample_valid && !sample_stall)
            expected_pixels = {expected_pixels, colorize(sample)};
    end

    always @(posedge clk)
    begin
        pixel_t want;
        cycle_count <= cycle_count + 1;
        if (rst_n && pixel_valid && !pixel_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected pixel %h", pixel);
                error_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (pixel.red !== want.red)
                begin
                    $error("red: expected %0d, actual %0d", want.red, pixel.red);
                    error_count++;
                end
                if (pixel.green !== want.green)
                begin
                    $error("green: expected %0d, actual %0d", want.green, pixel.green);
                    error_count++;
                end
                if (pixel.blue !== want.blue)
                begin
                    $error("blue: expected %0d, actual %0d", want.blue, pixel.blue);
                    error_count++;
                end
                if (pixel.alpha !== want.alpha)
                begin
                    $error("alpha: expected %0d, actual %0d", want.alpha, pixel.alpha);
                    error_count++;
                end
            end
        end
        if (cycle_count > CYCLE_CAP)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] lo;
        logic [31:0] hi;
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        pixel_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        cycle_count = 0;
        quiet_stretch = 1'b0;
        lo_bound = 0;
        hi_bound = 255;
        mode_reg = MODE_GRAY;
        map_reg = 3'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: gray over 0..255, with the edges, the middle and out-of-range values.
        push_sample(0, 0, 0);
        push_sample(255, 1, 2);
        push_sample(128, 0, 0);
        push_sample(32'h8000_0000, 32'h7FFF_FFFF, 0);
        push_sample(32'h7FFF_FFFF, 32'h8000_0000, 0);
        push_sample(-1, 3, 4);
        // Pseudocolor on every map, including unknown map codes, ends and middle.
        for (int m = 0; m < 8; m++)
        begin
            set_config(0, 255, MODE_PSEUDO, m[2:0]);
            push_sample(0, 0, 0);
            push_sample(255, 0, 0);
            push_sample(127, 0, 0);
        end
        // Three-band composite, the unused mode code and an empty range.
        set_config(32'h8000_0000, 32'h7FFF_FFFF, MODE_RGB, 3'd0);
        push_sample(32'h8000_0000, 32'h7FFF_FFFF, 0);
        set_config(-100, 100, 2'd3, 3'd5);
        push_sample(-100, 0, 100);
        set_config(50, 50, MODE_GRAY, 3'd0);
        push_sample(50, 51, 49);
        set_config(60, 10, MODE_PSEUDO, 3'd2);
        push_sample(60, 0, 0);
        set_config(60, 10, MODE_RGB, 3'd2);
        push_sample(60, 70, 0);

        for (int phase = 0; phase < 11; phase++)
        begin
            case (phase % 4)
                0:       begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
                1:       begin lo = $urandom_range(0, 200) - 100; hi = lo + $urandom_range(0, 3000); end
                2:       begin lo = $urandom; hi = $urandom; end
                default: begin lo = 0; hi = $urandom_range(1, 8); end
            endcase
            set_config(lo, hi, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
            quiet_stretch = (phase == 5);
            for (int k = 0; k < RANDOM_N / 11; k++)
                push_sample(rand_band(), rand_band(), rand_band());
        end
        quiet_stretch = 1'b0;

        wait_drained();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
